>>> src/bmc_pkg.sv
`default_nettype none
package bmc_pkg;

    // Field widths of one request.
    localparam int COORD_BITS = 16;
    localparam int AREA_BITS  = 20;
    localparam int CONF_BITS  = 16;

    // Configuration register widths and the port that carries them.
    localparam int MAXD_W   = 13;
    localparam int THR_W    = 15;
    localparam int SPEED_W  = 16;
    localparam int COS_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ONE_Q12 = 4096;

    // Squared lengths: centroid step, step to the prediction, velocity.
    localparam int DSQ_W = 2 * COORD_BITS + 1;
    localparam int PSQ_W = 2 * COORD_BITS + 3;
    localparam int VSQ_W = 2 * COORD_BITS;

    // Square root: squared length scaled by 256, one root bit per stage.
    localparam int SQ_STEPS = (PSQ_W + 8 + 1) / 2;
    localparam int SQ_W     = 2 * SQ_STEPS;
    localparam int LEN_W    = SQ_STEPS;

    // Distance ratio: (len * 16) / max_distance, one quotient bit per stage.
    localparam int DIVN_W    = LEN_W + 4;
    localparam int DIV_STEPS = DIVN_W;

    // Area ratio: min * 8192 / sum, quotient never above 4096.
    localparam int SUM_W      = AREA_BITS + 1;
    localparam int AQ_W       = 13;
    localparam int AREA_STEPS = AQ_W;

    // Direction test.
    localparam int DOT_W      = 2 * COORD_BITS + 2;
    localparam int DU_W       = 2 * COORD_BITS + 1;
    localparam int CA_W       = DSQ_W + COS_W;
    localparam int CB_W       = VSQ_W + COS_W;
    localparam int HW         = (CA_W + 1) / 2;
    localparam int CR_W       = CA_W + CB_W;
    localparam int DL         = (DU_W + 1) / 2;
    localparam int DOT2_W     = 2 * DU_W;
    localparam int COS_STAGES = 4;

    // Running score before saturation.
    localparam int CONF_W = DIVN_W + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DISTANCE  = 3'd0,
        CFG_BONUS_THR     = 3'd1,
        CFG_SPEED_LIMIT   = 3'd2,
        CFG_FLOOR_THR     = 3'd3,
        CFG_COSINE_THR    = 3'd4
    } t_cfg_idx;

endpackage
`default_nettype wire

>>> src/bmc_isqrt_pipe.sv
`default_nettype none
module bmc_isqrt_pipe (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [bmc_pkg::SQ_W-1:0]   i_val,
    output logic [bmc_pkg::LEN_W-1:0]  o_root
);
    import bmc_pkg::*;

    logic [SQ_W-1:0] r_v [0:SQ_STEPS-1];
    logic [SQ_W-1:0] r_r [0:SQ_STEPS-1];

    genvar g;
    for (g = 0; g < SQ_STEPS; g++) begin : g_step
        localparam logic [SQ_W-1:0] StepBit = SQ_W'(1) << (2 * (SQ_STEPS - 1 - g));
        logic [SQ_W-1:0] v_in;
        logic [SQ_W-1:0] q_in;
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] n_v;
        logic [SQ_W-1:0] n_r;

        if (g == 0) begin : g_first
            assign v_in = i_val;
            assign q_in = '0;
        end else begin : g_rest
            assign v_in = r_v[g-1];
            assign q_in = r_r[g-1];
        end

        always_comb begin
            trial = q_in + StepBit;
            if (v_in >= trial) begin
                n_v = v_in - trial;
                n_r = (q_in >> 1) + StepBit;
            end else begin
                n_v = v_in;
                n_r = q_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g] <= n_v;
                r_r[g] <= n_r;
            end
        end
    end

    assign o_root = r_r[SQ_STEPS-1][LEN_W-1:0];

endmodule
`default_nettype wire

>>> src/bmc_div_pipe.sv
`default_nettype none
module bmc_div_pipe (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [bmc_pkg::DIVN_W-1:0]  i_num,
    input  logic [bmc_pkg::MAXD_W-1:0]  i_den,
    output logic [bmc_pkg::DIVN_W-1:0]  o_quo
);
    import bmc_pkg::*;

    // Numerator bits leave at the top of r_nq while quotient bits enter below.
    logic [MAXD_W-1:0] r_rem [0:DIV_STEPS-1];
    logic [DIVN_W-1:0] r_nq  [0:DIV_STEPS-1];

    genvar g;
    for (g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [MAXD_W-1:0] rem_in;
        logic [DIVN_W-1:0] nq_in;
        logic [MAXD_W:0]   t;
        logic [MAXD_W:0]   diff;
        logic              ge;
        logic [MAXD_W-1:0] n_rem;
        logic [DIVN_W-1:0] n_nq;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
        end else begin : g_rest
            assign rem_in = r_rem[g-1];
            assign nq_in  = r_nq[g-1];
        end

        always_comb begin
            t     = {rem_in, nq_in[DIVN_W-1]};
            diff  = t - {1'b0, i_den};
            ge    = (t >= {1'b0, i_den});
            n_rem = ge ? diff[MAXD_W-1:0] : t[MAXD_W-1:0];
            n_nq  = {nq_in[DIVN_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_nq[g]  <= n_nq;
            end
        end
    end

    assign o_quo = r_nq[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> src/bmc_area_pipe.sv
`default_nettype none
module bmc_area_pipe (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bmc_pkg::AREA_BITS-1:0] i_mn,
    input  logic [bmc_pkg::SUM_W-1:0]     i_sum,
    output logic [bmc_pkg::AQ_W-1:0]      o_area
);
    import bmc_pkg::*;

    // The smaller area is below the sum, so only the thirteen fractional
    // quotient bits remain to be found.
    logic [SUM_W-1:0] r_rem  [0:AREA_STEPS-1];
    logic [SUM_W-1:0] r_den  [0:AREA_STEPS-1];
    logic [AQ_W-1:0]  r_q    [0:AREA_STEPS-1];
    logic             r_zero [0:AREA_STEPS-1];

    genvar g;
    for (g = 0; g < AREA_STEPS; g++) begin : g_step
        logic [SUM_W-1:0] rem_in;
        logic [SUM_W-1:0] den_in;
        logic [AQ_W-1:0]  q_in;
        logic             zero_in;
        logic [SUM_W:0]   t;
        logic [SUM_W:0]   diff;
        logic             ge;
        logic [SUM_W-1:0] n_rem;

        if (g == 0) begin : g_first
            assign rem_in  = SUM_W'(i_mn);
            assign den_in  = i_sum;
            assign q_in    = '0;
            assign zero_in = (i_sum == '0);
        end else begin : g_rest
            assign rem_in  = r_rem[g-1];
            assign den_in  = r_den[g-1];
            assign q_in    = r_q[g-1];
            assign zero_in = r_zero[g-1];
        end

        always_comb begin
            t     = {rem_in, 1'b0};
            diff  = t - {1'b0, den_in};
            ge    = (t >= {1'b0, den_in});
            n_rem = ge ? diff[SUM_W-1:0] : t[SUM_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_den[g]  <= den_in;
                r_q[g]    <= {q_in[AQ_W-2:0], ge};
                r_zero[g] <= zero_in;
            end
        end
    end

    assign o_area = r_zero[AREA_STEPS-1] ? AQ_W'(ONE_Q12) : r_q[AREA_STEPS-1];

endmodule
`default_nettype wire

>>> src/bmc_cos_pipe.sv
`default_nettype none
module bmc_cos_pipe (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [bmc_pkg::DOT_W-1:0]  i_dot,
    input  logic [bmc_pkg::DSQ_W-1:0]         i_dsq,
    input  logic [bmc_pkg::VSQ_W-1:0]         i_vsq,
    input  logic [bmc_pkg::COS_W-1:0]         i_cos,
    output logic                              o_par
);
    import bmc_pkg::*;

    // (dot * 4096)^2 >= (c * |d|^2) * (c * |v|^2), wide products split in halves.
    logic [CA_W-1:0]           r_a;
    logic [CB_W-1:0]           r_b;
    logic [DU_W-1:0]           r_du;
    logic                      r_ok1;
    logic [2*HW-1:0]           r_p00;
    logic [CB_W-1:0]           r_p01;
    logic [CA_W-1:0]           r_p10;
    logic [CA_W+CB_W-2*HW-1:0] r_p11;
    logic [2*DL-1:0]           r_q00;
    logic [DU_W-1:0]           r_q01;
    logic [2*(DU_W-DL)-1:0]    r_q11;
    logic                      r_ok2;
    logic [CR_W-1:0]           r_r;
    logic [DOT2_W-1:0]         r_dot2;
    logic                      r_ok3;
    logic                      r_par;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= CA_W'(i_cos) * CA_W'(i_dsq);
            r_b   <= CB_W'(i_cos) * CB_W'(i_vsq);
            r_du  <= i_dot[DU_W-1:0];
            r_ok1 <= !i_dot[DOT_W-1] && (i_dsq != '0) && (i_vsq != '0);

            r_p00 <= (2*HW)'(r_a[HW-1:0]) * (2*HW)'(r_b[HW-1:0]);
            r_p01 <= CB_W'(r_a[HW-1:0]) * CB_W'(r_b[CB_W-1:HW]);
            r_p10 <= CA_W'(r_a[CA_W-1:HW]) * CA_W'(r_b[HW-1:0]);
            r_p11 <= (CA_W+CB_W-2*HW)'(r_a[CA_W-1:HW]) * (CA_W+CB_W-2*HW)'(r_b[CB_W-1:HW]);
            r_q00 <= (2*DL)'(r_du[DL-1:0]) * (2*DL)'(r_du[DL-1:0]);
            r_q01 <= DU_W'(r_du[DL-1:0]) * DU_W'(r_du[DU_W-1:DL]);
            r_q11 <= (2*(DU_W-DL))'(r_du[DU_W-1:DL]) * (2*(DU_W-DL))'(r_du[DU_W-1:DL]);
            r_ok2 <= r_ok1;

            r_r    <= (CR_W'(r_p11) << (2*HW)) + ((CR_W'(r_p01) + CR_W'(r_p10)) << HW)
                      + CR_W'(r_p00);
            r_dot2 <= (DOT2_W'(r_q11) << (2*DL)) + (DOT2_W'(r_q01) << (DL+1))
                      + DOT2_W'(r_q00);
            r_ok3  <= r_ok2;

            r_par <= r_ok3 && ((CR_W'(r_dot2) << 24) >= r_r);
        end
    end

    assign o_par = r_par;

endmodule
`default_nettype wire

>>> src/blob_match_confidence_unit.sv
`default_nettype none
// Blob match confidence unit: one score for each request of a new and an old blob.
// Its depth is set by the bit-per-stage square root and the bit-per-stage distance divider.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Reset (synchronous, active low) clears the valid bits and loads the register defaults.
module blob_match_confidence_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_kind,
    input  logic [bmc_pkg::COORD_BITS-1:0]           i_new_x,
    input  logic [bmc_pkg::COORD_BITS-1:0]           i_new_y,
    input  logic [bmc_pkg::AREA_BITS-1:0]            i_new_area,
    input  logic [bmc_pkg::COORD_BITS-1:0]           i_old_x,
    input  logic [bmc_pkg::COORD_BITS-1:0]           i_old_y,
    input  logic [bmc_pkg::AREA_BITS-1:0]            i_old_area,
    input  logic signed [bmc_pkg::COORD_BITS-1:0]    i_old_vel_x,
    input  logic signed [bmc_pkg::COORD_BITS-1:0]    i_old_vel_y,
    input  logic signed [bmc_pkg::COORD_BITS-1:0]    i_old_pred_x,
    input  logic signed [bmc_pkg::COORD_BITS-1:0]    i_old_pred_y,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [bmc_pkg::CONF_BITS-1:0]     o_confidence,
    input  logic                                     i_cfg_we,
    input  logic [bmc_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [bmc_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import bmc_pkg::*;

    localparam int C = COORD_BITS;

    // Stage numbers: each counts the registers after the input.
    localparam int S_AREA = 1 + AREA_STEPS;
    localparam int S_COS  = 3 + COS_STAGES;
    localparam int S_SQ   = 3 + SQ_STEPS;
    localparam int S_DIV  = S_SQ + DIV_STEPS;
    localparam int S_SUM  = S_DIV + 1;
    localparam int S_OUT  = S_SUM + 1;
    localparam int D_AREA = S_DIV - S_AREA;
    localparam int D_PAR  = S_DIV - S_COS;
    localparam int D_SPD  = S_DIV - S_SQ;
    localparam int P_W    = 2 * C + 1;
    localparam logic signed [CONF_W-1:0] ConfMax = CONF_W'(32767);
    localparam logic signed [CONF_W-1:0] ConfMin = -CONF_W'(32768);
    localparam logic signed [CONF_W-1:0] ConfOne = CONF_W'(ONE_Q12);

    // Configuration registers. The user is to change them only while no request is in
    // flight; the block does not enforce this, and the stages read them directly.
    logic [MAXD_W-1:0]  r_max_dist;
    logic [THR_W-1:0]   r_bonus_thr;
    logic [SPEED_W-1:0] r_speed_lim;
    logic [THR_W-1:0]   r_floor_thr;
    logic [COS_W-1:0]   r_cos_thr;
    logic [MAXD_W-1:0]  maxd_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist  <= MAXD_W'(560);
            r_bonus_thr <= THR_W'(9216);
            r_speed_lim <= SPEED_W'(320);
            r_floor_thr <= THR_W'(6144);
            r_cos_thr   <= COS_W'(3973);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DISTANCE: r_max_dist  <= i_cfg_data[MAXD_W-1:0];
                CFG_BONUS_THR:    r_bonus_thr <= i_cfg_data[THR_W-1:0];
                CFG_SPEED_LIMIT:  r_speed_lim <= i_cfg_data[SPEED_W-1:0];
                CFG_FLOOR_THR:    r_floor_thr <= i_cfg_data[THR_W-1:0];
                CFG_COSINE_THR:   r_cos_thr   <= i_cfg_data[COS_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero normalizing distance behaves as one pixel.
    assign maxd_eff = (r_max_dist == '0) ? MAXD_W'(1) : r_max_dist;

    // The whole pipeline moves together; it holds only while the final
    // result is waiting to be taken, so a new request is taken in the same
    // cycle that the waiting result leaves.
    logic           en;
    logic [S_OUT:1] r_vld;

    assign en          = !r_vld[S_OUT] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[S_OUT-1:1], i_in_valid};
        end
    end

    // Stage 1: differences, magnitudes, and the smaller area and the area sum.
    logic signed [C:0]   dx;
    logic signed [C:0]   dy;
    logic signed [C+1:0] pdx;
    logic signed [C+1:0] pdy;
    logic [C:0]          dxa;
    logic [C:0]          dya;
    logic [C+1:0]        pdxa;
    logic [C+1:0]        pdya;
    logic [C:0]          vxa;
    logic [C:0]          vya;

    always_comb begin
        dx   = $signed({1'b0, i_new_x}) - $signed({1'b0, i_old_x});
        dy   = $signed({1'b0, i_new_y}) - $signed({1'b0, i_old_y});
        pdx  = $signed({2'b00, i_new_x}) - $signed({{2{i_old_pred_x[C-1]}}, i_old_pred_x});
        pdy  = $signed({2'b00, i_new_y}) - $signed({{2{i_old_pred_y[C-1]}}, i_old_pred_y});
        dxa  = dx[C] ? -dx : dx;
        dya  = dy[C] ? -dy : dy;
        pdxa = pdx[C+1] ? -pdx : pdx;
        pdya = pdy[C+1] ? -pdy : pdy;
        vxa  = i_old_vel_x[C-1] ? -$signed({i_old_vel_x[C-1], i_old_vel_x})
                                : $signed({i_old_vel_x[C-1], i_old_vel_x});
        vya  = i_old_vel_y[C-1] ? -$signed({i_old_vel_y[C-1], i_old_vel_y})
                                : $signed({i_old_vel_y[C-1], i_old_vel_y});
    end

    logic signed [C:0]      r1_dx;
    logic signed [C:0]      r1_dy;
    logic [C-1:0]           r1_ax;
    logic [C-1:0]           r1_ay;
    logic [C:0]             r1_apx;
    logic [C:0]             r1_apy;
    logic [C-1:0]           r1_avx;
    logic [C-1:0]           r1_avy;
    logic signed [C-1:0]    r1_vx;
    logic signed [C-1:0]    r1_vy;
    logic [AREA_BITS-1:0]   r1_mn;
    logic [SUM_W-1:0]       r1_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx  <= dx;
            r1_dy  <= dy;
            r1_ax  <= dxa[C-1:0];
            r1_ay  <= dya[C-1:0];
            r1_apx <= pdxa[C:0];
            r1_apy <= pdya[C:0];
            r1_avx <= vxa[C-1:0];
            r1_avy <= vya[C-1:0];
            r1_vx  <= i_old_vel_x;
            r1_vy  <= i_old_vel_y;
            r1_mn  <= (i_new_area < i_old_area) ? i_new_area : i_old_area;
            r1_sum <= SUM_W'(i_new_area) + SUM_W'(i_old_area);
        end
    end

    // Stage 2: squares and the two halves of the dot product.
    logic [2*C-1:0]        r2_dxx;
    logic [2*C-1:0]        r2_dyy;
    logic [2*C+1:0]        r2_pxx;
    logic [2*C+1:0]        r2_pyy;
    logic [2*C-1:0]        r2_vxx;
    logic [2*C-1:0]        r2_vyy;
    logic signed [P_W-1:0] r2_pxv;
    logic signed [P_W-1:0] r2_pyv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dxx <= (2*C)'(r1_ax) * (2*C)'(r1_ax);
            r2_dyy <= (2*C)'(r1_ay) * (2*C)'(r1_ay);
            r2_pxx <= (2*C+2)'(r1_apx) * (2*C+2)'(r1_apx);
            r2_pyy <= (2*C+2)'(r1_apy) * (2*C+2)'(r1_apy);
            r2_vxx <= (2*C)'(r1_avx) * (2*C)'(r1_avx);
            r2_vyy <= (2*C)'(r1_avy) * (2*C)'(r1_avy);
            r2_pxv <= P_W'(r1_dx) * P_W'(r1_vx);
            r2_pyv <= P_W'(r1_dy) * P_W'(r1_vy);
        end
    end

    // Stage 3: squared lengths and the dot product.
    logic [DSQ_W-1:0]        r3_dsq;
    logic [PSQ_W-1:0]        r3_psq;
    logic [VSQ_W-1:0]        r3_vsq;
    logic signed [DOT_W-1:0] r3_dot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dsq <= DSQ_W'(r2_dxx) + DSQ_W'(r2_dyy);
            r3_psq <= PSQ_W'(r2_pxx) + PSQ_W'(r2_pyy);
            r3_vsq <= r2_vxx + r2_vyy;
            r3_dot <= DOT_W'(r2_pxv) + DOT_W'(r2_pyv);
        end
    end

    // Area ratio, running alongside from stage 1.
    logic [AQ_W-1:0] area_q;

    bmc_area_pipe u_area (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mn   (r1_mn),
        .i_sum  (r1_sum),
        .o_area (area_q)
    );

    // Direction test from stage 3.
    logic par;

    bmc_cos_pipe u_cos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dot (r3_dot),
        .i_dsq (r3_dsq),
        .i_vsq (r3_vsq),
        .i_cos (r_cos_thr),
        .o_par (par)
    );

    // Three lengths in Q.4 pixels.
    logic [LEN_W-1:0] len_d;
    logic [LEN_W-1:0] len_p;
    logic [LEN_W-1:0] len_v;

    bmc_isqrt_pipe u_sqrt_d (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (SQ_W'({r3_dsq, 8'b0})),
        .o_root (len_d)
    );

    bmc_isqrt_pipe u_sqrt_p (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (SQ_W'({r3_psq, 8'b0})),
        .o_root (len_p)
    );

    bmc_isqrt_pipe u_sqrt_v (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (SQ_W'({r3_vsq, 8'b0})),
        .o_root (len_v)
    );

    // Speed change in Q.4 against the limit, which is in whole pixels and so scaled by 16.
    logic [LEN_W-1:0] dchg;
    logic             spd_ok;

    always_comb begin
        dchg   = (len_v >= len_d) ? (len_v - len_d) : (len_d - len_v);
        spd_ok = (32'(dchg) <= 32'({r_speed_lim, 4'b0}));
    end

    // Distance ratios of the centroid step and of the step to the prediction.
    logic [DIVN_W-1:0] quo_d;
    logic [DIVN_W-1:0] quo_p;

    bmc_div_pipe u_div_d (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({len_d, 4'b0}),
        .i_den (maxd_eff),
        .o_quo (quo_d)
    );

    bmc_div_pipe u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({len_p, 4'b0}),
        .i_den (maxd_eff),
        .o_quo (quo_p)
    );

    // Side values wait here until the dividers finish.
    logic [S_SUM:1]  r_kind;
    logic [AQ_W-1:0] r_area_d [0:D_AREA-1];
    logic [D_PAR-1:0] r_par_d;
    logic [D_SPD-1:0] r_spd_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind     <= {r_kind[S_SUM-1:1], i_kind};
            r_par_d    <= {r_par_d[D_PAR-2:0], par};
            r_spd_d    <= {r_spd_d[D_SPD-2:0], spd_ok};
            r_area_d[0] <= area_q;
            for (int i = 1; i < D_AREA; i++) begin
                r_area_d[i] <= r_area_d[i-1];
            end
        end
    end

    // Sum stage: the full three-term score for kind 0, two terms for kind 1.
    logic signed [CONF_W-1:0] term_d;
    logic signed [CONF_W-1:0] term_p;
    logic signed [CONF_W-1:0] n_sum;
    logic signed [CONF_W-1:0] r_sum;
    logic                     r_sum_par;
    logic                     r_sum_spd;

    always_comb begin
        term_d = ConfOne - $signed(CONF_W'(quo_d));
        term_p = ConfOne - $signed(CONF_W'(quo_p));
        n_sum  = $signed(CONF_W'(r_area_d[D_AREA-1])) + term_d;
        if (!r_kind[S_DIV]) begin
            n_sum = n_sum + term_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum     <= n_sum;
            r_sum_par <= r_par_d[D_PAR-1];
            r_sum_spd <= r_spd_d[D_SPD-1];
        end
    end

    // Output stage: for kind 0, a strong, steady match skips the floor check and gains
    // the bonus if it is also parallel; everything then saturates to Q3.12.
    logic signed [CONF_W-1:0]    adj;
    logic signed [CONF_BITS-1:0] n_conf;
    logic signed [CONF_BITS-1:0] r_conf;
    logic                        r_out_kind;

    always_comb begin
        adj = r_sum;
        if (!r_kind[S_SUM]) begin
            if ((r_sum >= $signed(CONF_W'(r_bonus_thr))) && r_sum_spd) begin
                if (r_sum_par) begin
                    adj = r_sum + ConfOne;
                end
            end else if (r_sum < $signed(CONF_W'(r_floor_thr))) begin
                adj = '0;
            end
        end
        if (adj > ConfMax) begin
            n_conf = CONF_BITS'(ConfMax);
        end else if (adj < ConfMin) begin
            n_conf = CONF_BITS'(ConfMin);
        end else begin
            n_conf = adj[CONF_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_conf     <= n_conf;
            r_out_kind <= r_kind[S_SUM];
        end
    end

    assign o_confidence = r_conf;

`ifndef SYNTHESIS
    // A held pipeline neither gains nor loses a request.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_vld))
        else $error("valid bits moved while the pipeline was held");

    // The area term never exceeds one.
    a_area_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_AREA] |-> (area_q <= AQ_W'(ONE_Q12)))
        else $error("area term above one");

    // Area and distance alone can reach two at most.
    a_kind1_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_kind) |-> (o_confidence <= 16'sd8192))
        else $error("two-term score above two");
`endif

endmodule
`default_nettype wire
